// File: sv/es2c_pkg.sv
// ----------------------------------------------------------------------------
// es2c_pkg
// Shared constants and the pipeline payload type for the epoch seconds to
// UTC calendar converter.
// ----------------------------------------------------------------------------
package es2c_pkg;

    // Number of register stages in the conversion pipeline
    localparam int NUM_STAGES = 9;

    // Reciprocal for (seconds >> 7) / 675, i.e. seconds / 86400
    localparam logic [22:0] DAY_RECIP   = 23'd6362914;
    localparam logic [9:0]  DAY_DIV     = 10'd675;

    // Reciprocal for (sec_of_day >> 4) / 225, i.e. sec_of_day / 3600
    localparam logic [8:0]  HOUR_RECIP  = 9'd291;
    localparam logic [16:0] SECS_HOUR   = 17'd3600;

    // Reciprocal for (sec_of_hour >> 2) / 15, i.e. sec_of_hour / 60
    localparam logic [12:0] MIN_RECIP   = 13'd4369;
    localparam logic [11:0] SECS_MIN    = 12'd60;

    // Weekday: day 0 was a Thursday, so (days + 4) mod 7
    localparam logic [15:0] WDAY_OFS    = 16'd4;
    localparam logic [16:0] WEEK_RECIP  = 17'd74898;
    localparam logic [15:0] WEEK_DAYS   = 16'd7;

    // Year estimate: days / 365.25 scaled by 2^24
    localparam logic [15:0] YEAR_RECIP  = 16'd45934;
    localparam logic [16:0] YEAR_DAYS   = 17'd365;
    // Year offsets from 1970: 1900 base and the non-leap century 2100
    localparam logic [7:0]  YEAR_BASE   = 8'd70;
    localparam logic [7:0]  CENT_2100   = 8'd130;

    // First day of each month in a common year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Payload carried down the pipeline; each stage fills its own fields
    typedef struct packed {
        logic [24:0] x;
        logic [6:0]  lo7;
        logic [15:0] q;
        logic [25:0] prod;
        logic [15:0] days;
        logic [16:0] in_day;
        logic [4:0]  h;
        logic [15:0] dp4;
        logic [13:0] q7;
        logic [7:0]  yest;
        logic [16:0] hprod;
        logic [15:0] wprod;
        logic [15:0] d0;
        logic [15:0] d1;
        logic [15:0] d2;
        logic [4:0]  hour;
        logic [11:0] hr_rem;
        logic [2:0]  wday;
        logic [7:0]  ys1900;
        logic [8:0]  yday;
        logic        leap;
        logic [5:0]  mest;
        logic [3:0]  mon;
        logic [11:0] mprod;
        logic [4:0]  mday;
        logic [5:0]  minute;
        logic [5:0]  second;
    } pipe_t;

endpackage

// File: sv/es2c_pipe_ctl.sv
// ----------------------------------------------------------------------------
// es2c_pipe_ctl
// Valid tracking and per-stage load enables for the conversion pipeline.
// A stage loads when it is empty or the stage after it is loading, so
// bubbles collapse and a stall at the output holds every occupied stage.
// ----------------------------------------------------------------------------
module es2c_pipe_ctl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_ready,
    output logic                              dst_valid,
    input  logic                              dst_ready,
    output logic [es2c_pkg::NUM_STAGES-1:0]   stage_en
);

    localparam int LAST = es2c_pkg::NUM_STAGES - 1;

    logic [es2c_pkg::NUM_STAGES-1:0] v_reg;
    logic [es2c_pkg::NUM_STAGES-1:0] v_next;
    logic [es2c_pkg::NUM_STAGES-1:0] en_c;

    // Load enables ripple back from the output
    always_comb
    begin
        en_c[LAST] = !v_reg[LAST] || dst_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en_c[k] = !v_reg[k] || en_c[k+1];
        end
    end

    // Valid bits move with the data
    always_comb
    begin
        v_next[0] = en_c[0] ? src_valid : v_reg[0];
        for (int k = 1; k <= LAST; k++)
        begin
            v_next[k] = en_c[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign stage_en  = en_c;
    assign src_ready = en_c[0];
    assign dst_valid = v_reg[LAST];

`ifndef ASSERT_OFF
    // Items in flight change only by transfers at the two ends
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(v_reg) == $past($countones(v_reg))
            + ($past(src_valid && src_ready) ? 1 : 0)
            - ($past(dst_valid && dst_ready) ? 1 : 0)))
        else $error("pipeline occupancy does not match transfers");

    // Input is refused only when every stage holds an item
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> (&v_reg))
        else $error("input blocked while a stage is empty");

    // A stalled result holds every stage behind it
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !dst_ready |=> (&v_reg))
        else $error("full pipeline lost an item under stall");
`endif

endmodule

// File: sv/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC
// into broken-down UTC calendar fields (Gregorian leap rule).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: epoch_seconds with src_valid / src_ready. A transfer
//   happens on a rising clk edge with both high.
//   Output channel: second, minute, hour, weekday, years_since_1900,
//   day_of_year, month, month_day with dst_valid / dst_ready.
//   Pipeline: nine register stages (day split, hour/weekday/year estimates
//   and their corrections, month search, minute split).
//   Throughput: one item per cycle while the output is not stalled; every stage is about one multiply deep.
//   Reset (rst_n low, asynchronous) empties the pipeline; the block keeps
//   no other state and has no configuration.
//   When the receiver holds dst_ready low, the result stays on the output
//   ports and items pile up behind it; src_ready drops only once all nine
//   stages are occupied. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [31:0] epoch_seconds,
    output logic        dst_valid,
    input  logic        dst_ready,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [7:0]  years_since_1900,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month,
    output logic [4:0]  month_day
);

    localparam int LAST = es2c_pkg::NUM_STAGES - 1;

    es2c_pkg::pipe_t s_reg  [es2c_pkg::NUM_STAGES];
    es2c_pkg::pipe_t s_next [es2c_pkg::NUM_STAGES];

    logic [es2c_pkg::NUM_STAGES-1:0] stage_en;

    logic [47:0] p_day;
    logic [21:0] p_hour;
    logic [15:0] dp4_c;
    logic [32:0] p_week;
    logic [31:0] p_year;
    logic [22:0] p_min;
    logic [10:0] r_day;
    logic [16:0] r_hour;
    logic [15:0] r_wday;
    logic [11:0] r_min;
    logic [7:0]  yc0;
    logic [7:0]  yc2;
    logic [3:0]  mon_c;

    // Days before year 1970 + c: 365c + leap days since 1972, less 2100
    function automatic logic [15:0] year_start(input logic [7:0] c);
        logic [16:0] acc;
        logic [8:0]  lp;
        acc = 17'(c) * es2c_pkg::YEAR_DAYS;
        lp  = (9'(c) + 9'd1) >> 2;
        acc = acc + 17'(lp);
        if (c > es2c_pkg::CENT_2100)
        begin
            acc = acc - 17'd1;
        end
        return acc[15:0];
    endfunction

    // First day of month m, one later from March on in a leap year
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic lp);
        logic [8:0] st;
        st = es2c_pkg::MONTH_START[m];
        if (lp && (m >= 4'd2))
        begin
            st = st + 9'd1;
        end
        return st;
    endfunction

    // Handshake and stage enables
    es2c_pipe_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .stage_en  (stage_en)
    );

    // Arithmetic taps per stage
    assign p_day  = 48'(epoch_seconds[31:7]) * 48'(es2c_pkg::DAY_RECIP);
    assign r_day  = 11'(s_reg[1].x - s_reg[1].prod[24:0]);
    assign p_hour = 22'(s_reg[2].in_day[16:4]) * 22'(es2c_pkg::HOUR_RECIP);
    assign dp4_c  = s_reg[2].days + es2c_pkg::WDAY_OFS;
    assign p_week = 33'(dp4_c) * 33'(es2c_pkg::WEEK_RECIP);
    assign p_year = 32'(s_reg[2].days) * 32'(es2c_pkg::YEAR_RECIP);
    assign r_hour = s_reg[4].in_day - s_reg[4].hprod;
    assign r_wday = s_reg[4].dp4 - s_reg[4].wprod;
    assign yc0    = s_reg[4].yest - 8'd1;
    assign yc2    = s_reg[4].yest + 8'd1;
    assign p_min  = 23'(s_reg[5].hr_rem[11:2]) * 23'(es2c_pkg::MIN_RECIP);
    assign r_min  = s_reg[7].hr_rem - s_reg[7].mprod;

    // Month: last month whose first day is not after the day of year
    always_comb
    begin
        mon_c = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (s_reg[5].yday >= month_start(4'(k), s_reg[5].leap))
            begin
                mon_c = 4'(k);
            end
        end
    end

    // Next value of each stage
    always_comb
    begin
        // Stage 0: day count estimate
        s_next[0]     = '0;
        s_next[0].x   = epoch_seconds[31:7];
        s_next[0].lo7 = epoch_seconds[6:0];
        s_next[0].q   = p_day[47:32];

        // Stage 1: back-multiply the estimate
        s_next[1]      = s_reg[0];
        s_next[1].prod = 26'(s_reg[0].q) * 26'(es2c_pkg::DAY_DIV);

        // Stage 2: correct day count, form seconds of day
        s_next[2] = s_reg[1];
        if (r_day >= 11'(es2c_pkg::DAY_DIV))
        begin
            s_next[2].days   = s_reg[1].q + 16'd1;
            s_next[2].in_day = {10'(r_day - 11'(es2c_pkg::DAY_DIV)), s_reg[1].lo7};
        end
        else
        begin
            s_next[2].days   = s_reg[1].q;
            s_next[2].in_day = {r_day[9:0], s_reg[1].lo7};
        end

        // Stage 3: hour, weekday and year estimates
        s_next[3]      = s_reg[2];
        s_next[3].h    = p_hour[20:16];
        s_next[3].dp4  = dp4_c;
        s_next[3].q7   = p_week[32:19];
        s_next[3].yest = p_year[31:24];

        // Stage 4: back-multiplies and candidate year starts
        s_next[4]       = s_reg[3];
        s_next[4].hprod = 17'(s_reg[3].h) * es2c_pkg::SECS_HOUR;
        s_next[4].wprod = 16'(s_reg[3].q7) * es2c_pkg::WEEK_DAYS;
        s_next[4].d0    = year_start(s_reg[3].yest - 8'd1);
        s_next[4].d1    = year_start(s_reg[3].yest);
        s_next[4].d2    = year_start(s_reg[3].yest + 8'd1);

        // Stage 5: correct hour and weekday, pick the year
        s_next[5] = s_reg[4];
        if (r_hour >= es2c_pkg::SECS_HOUR)
        begin
            s_next[5].hour   = s_reg[4].h + 5'd1;
            s_next[5].hr_rem = 12'(r_hour - es2c_pkg::SECS_HOUR);
        end
        else
        begin
            s_next[5].hour   = s_reg[4].h;
            s_next[5].hr_rem = r_hour[11:0];
        end
        if (r_wday >= es2c_pkg::WEEK_DAYS)
        begin
            s_next[5].wday = 3'(r_wday - es2c_pkg::WEEK_DAYS);
        end
        else
        begin
            s_next[5].wday = r_wday[2:0];
        end
        if (s_reg[4].days < s_reg[4].d1)
        begin
            s_next[5].ys1900 = yc0 + es2c_pkg::YEAR_BASE;
            s_next[5].yday   = 9'(s_reg[4].days - s_reg[4].d0);
            s_next[5].leap   = (yc0[1:0] == 2'd2) && (yc0 != es2c_pkg::CENT_2100);
        end
        else if (s_reg[4].days >= s_reg[4].d2)
        begin
            s_next[5].ys1900 = yc2 + es2c_pkg::YEAR_BASE;
            s_next[5].yday   = 9'(s_reg[4].days - s_reg[4].d2);
            s_next[5].leap   = (yc2[1:0] == 2'd2) && (yc2 != es2c_pkg::CENT_2100);
        end
        else
        begin
            s_next[5].ys1900 = s_reg[4].yest + es2c_pkg::YEAR_BASE;
            s_next[5].yday   = 9'(s_reg[4].days - s_reg[4].d1);
            s_next[5].leap   = (s_reg[4].yest[1:0] == 2'd2)
                               && (s_reg[4].yest != es2c_pkg::CENT_2100);
        end

        // Stage 6: minute estimate, month search
        s_next[6]      = s_reg[5];
        s_next[6].mest = p_min[21:16];
        s_next[6].mon  = mon_c;

        // Stage 7: minute back-multiply, day of month
        s_next[7]       = s_reg[6];
        s_next[7].mprod = 12'(s_reg[6].mest) * es2c_pkg::SECS_MIN;
        s_next[7].mday  = 5'(s_reg[6].yday - month_start(s_reg[6].mon, s_reg[6].leap)
                             + 9'd1);

        // Stage 8: correct minute, seconds remain
        s_next[8] = s_reg[7];
        if (r_min >= es2c_pkg::SECS_MIN)
        begin
            s_next[8].minute = s_reg[7].mest + 6'd1;
            s_next[8].second = 6'(r_min - es2c_pkg::SECS_MIN);
        end
        else
        begin
            s_next[8].minute = s_reg[7].mest;
            s_next[8].second = r_min[5:0];
        end
    end

    // Payload stages load on their enable
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < es2c_pkg::NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                s_reg[k] <= s_next[k];
            end
        end
    end

    // Result fields
    assign second           = s_reg[LAST].second;
    assign minute           = s_reg[LAST].minute;
    assign hour             = s_reg[LAST].hour;
    assign weekday          = s_reg[LAST].wday;
    assign years_since_1900 = s_reg[LAST].ys1900;
    assign day_of_year      = s_reg[LAST].yday;
    assign month            = s_reg[LAST].mon;
    assign month_day        = s_reg[LAST].mday;

`ifndef ASSERT_OFF
    // Time-of-day corrections left every field in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
                      && (weekday < 3'd7))
        else $error("time of day field out of range");

    // Year and month selection left the date in range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (month < 4'd12) && (month_day != 5'd0)
                      && (day_of_year < 9'd366) && (years_since_1900 >= 8'd70))
        else $error("calendar field out of range");

    // The last day of a leap year is the 31st of December
    a_year_end: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && (day_of_year == 9'd365) |-> (month == 4'd11) && (month_day == 5'd31))
        else $error("day 365 not on December 31");
`endif

endmodule
